>>> design/lcs_pkg.sv
// Package with payload types and status codes for the linear congruence solver.
package lcs_pkg;

  typedef enum logic [1:0] {
    ST_SOLVED   = 2'd0,
    ST_NO_SOL   = 2'd1,
    ST_BAD_MOD  = 2'd2
  } lcs_status_t;

  typedef struct packed {
    logic [31:0] coef_a;
    logic [31:0] rhs_b;
    logic [31:0] modulus_m;
  } lcs_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] base_solution;
    logic [31:0] solution_step;
    logic [31:0] solution_count;
  } lcs_out_t;

endpackage

>>> design/lcs_divider.sv
// Restoring bit-serial divider shared by all divide and modulo steps.
module lcs_divider import lcs_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [WIDTH:0]   trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[WIDTH-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt    = WIDTH'(trial - {1'b0, dvs_r});
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[WIDTH-1:0];
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

>>> design/linear_congruence_solver_core.sv
// Top level of the linear congruence solver: sequencer around a shared divider.
//
// Solves a*x = b (mod m). One input transfer on in_ (coef_a, rhs_b,
// modulus_m) produces exactly one result transfer on out_ (status,
// base_solution, solution_step, solution_count).
// The block takes one item at a time. in_stall is high from the accepted
// transfer until the result has been handed to the output register.
// Divisions go through the bit-serial divider. A zero modulus is answered
// without a division. Otherwise the gcd takes one division per Euclid
// step, five divisions prepare the reduced operands, each extended-Euclid
// step takes one division plus a shift-and-add modular multiply that
// handles one quotient bit per cycle, and a final shift-and-add product
// gives the base solution.
// The result sits in an output register; while out_stall is high it holds,
// the next item may be accepted and worked on meanwhile, and that item
// waits in its final state until the register is free.
// A synchronous active-low reset returns the sequencer to idle and drops
// out_valid; any item in flight is discarded.
module linear_congruence_solver_core import lcs_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  lcs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output lcs_out_t out_data
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_CHECK = 15'b000000000000010,
    S_GCD   = 15'b000000000000100,
    S_GCDW  = 15'b000000000001000,
    S_BMOD  = 15'b000000000010000,
    S_M1    = 15'b000000000100000,
    S_A1    = 15'b000000001000000,
    S_B1    = 15'b000000010000000,
    S_EUC   = 15'b000000100000000,
    S_EUCW  = 15'b000001000000000,
    S_MUL   = 15'b000010000000000,
    S_FMUL  = 15'b000100000000000,
    S_DONE  = 15'b001000000000000,
    S_WDIV  = 15'b010000000000000,
    S_MSET  = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;   // state to resume once a division finishes

  logic [WIDTH-1:0] a_r, a_nxt, b_r, b_nxt, m_r, m_nxt;
  logic [WIDTH-1:0] p_r, p_nxt, q_r, q_nxt;      // Euclid pair
  logic [WIDTH-1:0] d_r, d_nxt, m1_r, m1_nxt;
  logic [WIDTH-1:0] t0_r, t0_nxt, t1_r, t1_nxt;
  // Shift-and-add multiply operands: acc += x for each set bit of y.
  logic [WIDTH-1:0] mx_r, mx_nxt, my_r, my_nxt, acc_r, acc_nxt;
  lcs_status_t      stat_r, stat_nxt;
  lcs_out_t         res_r, res_nxt;
  logic             ovld_r, ovld_nxt;

  logic             div_start;
  logic [WIDTH-1:0] div_n, div_d, div_q, div_rm;
  logic             div_done;

  lcs_divider #(.WIDTH(WIDTH)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_n),
    .divisor   (div_d),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rm)
  );

  // Modular add of two residues below m1_r, without overflow.
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] room;
    room = m - y;
    if (x >= room) return x - room;
    return x + y;
  endfunction

  function automatic logic [31:0] to32(input logic [WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  logic [WIDTH-1:0] in_a, in_b, in_m;
  assign in_a = WIDTH'(in_data.coef_a);
  assign in_b = WIDTH'(in_data.rhs_b);
  assign in_m = WIDTH'(in_data.modulus_m);

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    a_nxt = a_r; b_nxt = b_r; m_nxt = m_r;
    p_nxt = p_r; q_nxt = q_r; d_nxt = d_r; m1_nxt = m1_r;
    t0_nxt = t0_r; t1_nxt = t1_r;
    mx_nxt = mx_r; my_nxt = my_r; acc_nxt = acc_r;
    stat_nxt = stat_r;
    res_nxt  = res_r;
    ovld_nxt = ovld_r && out_stall;
    div_start = 1'b0;
    div_n = p_r;
    div_d = q_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          a_nxt = in_a; b_nxt = in_b; m_nxt = in_m;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (m_r == '0) begin
          stat_nxt = ST_BAD_MOD;
          state_nxt = S_DONE;
        end else begin
          // a mod m first; Euclid pair is (m, a mod m).
          div_n = a_r; div_d = m_r; div_start = 1'b1;
          p_nxt = m_r;
          ret_nxt = S_GCD;
          state_nxt = S_WDIV;
        end
      end
      S_GCD: begin
        // Entered with div_rm = a mod m, or with the remainder of the last Euclid step.
        q_nxt = div_rm;
        state_nxt = S_GCDW;
      end
      S_GCDW: begin
        if (q_r == '0) begin
          d_nxt = p_r;
          div_n = b_r; div_d = p_r; div_start = 1'b1;
          ret_nxt = S_BMOD;
          state_nxt = S_WDIV;
        end else begin
          div_n = p_r; div_d = q_r; div_start = 1'b1;
          p_nxt = q_r;
          ret_nxt = S_GCD;
          state_nxt = S_WDIV;
        end
      end
      S_BMOD: begin
        if (div_rm != '0) begin
          stat_nxt = ST_NO_SOL;
          state_nxt = S_DONE;
        end else begin
          b_nxt = div_q;  // b / d
          div_n = m_r; div_d = d_r; div_start = 1'b1;
          ret_nxt = S_M1;
          state_nxt = S_WDIV;
        end
      end
      S_M1: begin
        m1_nxt = div_q;
        if (div_q <= WIDTH'(1)) begin
          acc_nxt = '0;
          state_nxt = S_FMUL;
          my_nxt = '0;
        end else begin
          div_n = a_r; div_d = d_r; div_start = 1'b1;
          ret_nxt = S_A1;
          state_nxt = S_WDIV;
        end
      end
      S_A1: begin
        div_n = div_q; div_d = m1_r; div_start = 1'b1;
        ret_nxt = S_B1;
        state_nxt = S_WDIV;
      end
      S_B1: begin
        // div_rm = a1; start b1 = (b/d) mod m1.
        q_nxt = div_rm;
        p_nxt = m1_r;
        t0_nxt = '0;
        t1_nxt = WIDTH'(1);
        div_n = b_r; div_d = m1_r; div_start = 1'b1;
        ret_nxt = S_EUC;
        state_nxt = S_WDIV;
      end
      S_EUC: begin
        // The division that just finished gives b1.
        b_nxt = div_rm;
        state_nxt = S_EUCW;
      end
      S_EUCW: begin
        if (q_r == '0) begin
          // Inverse is t0; x0 = b1 * t0 mod m1.
          acc_nxt = '0;
          mx_nxt = b_r;
          my_nxt = t0_r;
          state_nxt = S_FMUL;
        end else begin
          div_n = p_r; div_d = q_r; div_start = 1'b1;
          ret_nxt = S_MSET;
          state_nxt = S_WDIV;
        end
      end
      S_MSET: begin
        // Load the multiply of the Euclid quotient by t1 and advance the pair.
        mx_nxt = t1_r;
        my_nxt = div_q;
        acc_nxt = '0;
        p_nxt = q_r;
        q_nxt = div_rm;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        // Compute q * t1 mod m1 by shift and add, then t2 = t0 - q * t1.
        if (my_r == '0) begin
          t0_nxt = t1_r;
          t1_nxt = (t0_r >= acc_r) ? t0_r - acc_r : t0_r + (m1_r - acc_r);
          state_nxt = S_EUCW;
        end else begin
          if (my_r[0]) acc_nxt = add_mod(acc_r, mx_r, m1_r);
          mx_nxt = add_mod(mx_r, mx_r, m1_r);
          my_nxt = my_r >> 1;
        end
      end
      S_FMUL: begin
        if (my_r == '0) begin
          stat_nxt = ST_SOLVED;
          state_nxt = S_DONE;
        end else begin
          if (my_r[0]) acc_nxt = add_mod(acc_r, mx_r, m1_r);
          mx_nxt = add_mod(mx_r, mx_r, m1_r);
          my_nxt = my_r >> 1;
        end
      end
      S_DONE: begin
        // Hand the result over once the output register is free.
        if (!ovld_r || !out_stall) begin
          res_nxt = '0;
          res_nxt.status = stat_r;
          if (stat_r == ST_SOLVED) begin
            res_nxt.base_solution  = to32(acc_r);
            res_nxt.solution_step  = to32(m1_r);
            res_nxt.solution_count = to32(d_r);
          end
          ovld_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_WDIV: begin
        if (div_done) state_nxt = ret_r;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      ovld_r  <= 1'b0;
      mx_r    <= '0;
      my_r    <= '0;
      acc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      ovld_r  <= ovld_nxt;
      mx_r    <= mx_nxt;
      my_r    <= my_nxt;
      acc_r   <= acc_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; m_r <= m_nxt;
    p_r <= p_nxt; q_r <= q_nxt; d_r <= d_nxt; m1_r <= m1_nxt;
    t0_r <= t0_nxt; t1_r <= t1_nxt;
    stat_r <= stat_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid = ovld_r;
  assign out_data  = res_r;

endmodule

>>> design/lcs_checker.sv
// Port-level checker for the linear congruence solver, bound to the top level.
module lcs_checker import lcs_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input lcs_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input lcs_out_t out_data
);

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // After an input transfer the block is busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after input transfer");

  // Status never takes the unused code.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("illegal status code");

  // Failed items carry zero base_solution and solution_count fields.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_SOLVED |->
      out_data.base_solution == '0 && out_data.solution_count == '0)
    else $error("nonzero fields on failed item");

endmodule

bind linear_congruence_solver_core lcs_checker u_lcs_checker (.*);

>>> test/tb_top.sv
// Testbench for the linear congruence solver: directed and random congruences checked in order.
module tb_top;
  import lcs_pkg::*;

  // Holds expected solutions in arrival order and checks each result transfer.
  class congruence_board;
    lcs_out_t pending_q[$];
    int errors;

    static function longint unsigned gcd64(longint unsigned p, longint unsigned q);
      longint unsigned r;
      while (q != 0) begin
        r = p % q;
        p = q;
        q = r;
      end
      return p;
    endfunction

    // Inverse of a modulo m with gcd(a, m) = 1, kept in [0, m).
    static function longint unsigned mod_inverse(longint unsigned a, longint unsigned m);
      longint unsigned r0, r1, r2, t0, t1, t2, q, prod;
      r0 = m; r1 = a; t0 = 0; t1 = 1;
      while (r1 != 0) begin
        q = r0 / r1;
        r2 = r0 - q * r1;
        prod = ((q % m) * t1) % m;
        t2 = (t0 >= prod) ? t0 - prod : t0 + (m - prod);
        r0 = r1; r1 = r2; t0 = t1; t1 = t2;
      end
      return t0;
    endfunction

    function void note_input(lcs_in_t item);
      lcs_out_t res;
      longint unsigned a, b, m, d, m1;
      res = '0;
      a = 64'(item.coef_a); b = 64'(item.rhs_b); m = 64'(item.modulus_m);
      if (m == 0) begin
        res.status = ST_BAD_MOD;
      end else begin
        d = gcd64(m, a % m);
        if (b % d != 0) begin
          res.status = ST_NO_SOL;
        end else begin
          m1 = m / d;
          res.status = ST_SOLVED;
          // Operands are below 2^32, so the 64-bit product cannot overflow.
          if (m1 > 1)
            res.base_solution =
              32'((((b / d) % m1) * mod_inverse((a / d) % m1, m1)) % m1);
          res.solution_step = 32'(m1);
          res.solution_count = 32'(d);
        end
      end
      pending_q.push_back(res);
    endfunction

    task check_result(lcs_out_t got);
      lcs_out_t exp_r;
      if (pending_q.size() == 0) begin
        report_err("result with nothing pending");
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.status !== exp_r.status)
        report_err($sformatf("status %0d, wanted %0d", got.status, exp_r.status));
      if (got.base_solution !== exp_r.base_solution)
        report_err($sformatf("base_solution %0d, wanted %0d",
                             got.base_solution, exp_r.base_solution));
      if (got.solution_step !== exp_r.solution_step)
        report_err($sformatf("solution_step %0d, wanted %0d",
                             got.solution_step, exp_r.solution_step));
      if (got.solution_count !== exp_r.solution_count)
        report_err($sformatf("solution_count %0d, wanted %0d",
                             got.solution_count, exp_r.solution_count));
    endtask

    task report_err(string msg);
      errors++;
      if (errors <= 50) $display("mismatch at %0t: %s", $time, msg);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  lcs_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  lcs_out_t out_data;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit stim_done = 0;
  congruence_board board = new();

  linear_congruence_solver_core uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Results are sampled at the rising edge; stall is redrawn at the falling edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Offers one item and holds it until the transfer happens. Valid stays
  // high afterwards so that back-to-back items need one assignment per edge.
  task automatic send_item(logic [31:0] a, logic [31:0] b, logic [31:0] m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_data <= '{coef_a: a, rhs_b: b, modulus_m: m};
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    board.note_input('{coef_a: a, rhs_b: b, modulus_m: m});
    @(negedge clk);
  endtask

  // Mostly small moduli keep the latency down; a few use the full range.
  task automatic send_random();
    logic [31:0] a, b, m, g;
    int kind;
    kind = $urandom_range(9);
    case (kind)
      0: begin
        m = $urandom; a = $urandom; b = $urandom;
      end
      1: begin
        m = $urandom_range(255); a = $urandom; b = $urandom;
      end
      2: begin
        // A shared factor makes the multi-solution and no-solution cases common.
        g = $urandom_range(64, 1);
        m = g * $urandom_range(1000, 1);
        a = g * $urandom_range(5000);
        b = ($urandom_range(1)) ? g * $urandom_range(5000) : $urandom_range(5000);
      end
      3: begin
        m = $urandom; a = $urandom_range(3); b = $urandom;
      end
      default: begin
        m = $urandom_range(65535); a = $urandom_range(65535); b = $urandom_range(65535);
      end
    endcase
    send_item(a, b, m);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Zero modulus, zero coefficient, step of one, no solution and field extremes.
    send_item(32'd5, 32'd7, 32'd0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_item(32'd0, 32'd0, 32'd7);
    send_item(32'd0, 32'd14, 32'd7);
    send_item(32'd0, 32'd3, 32'd7);
    send_item(32'd3, 32'd5, 32'd1);
    send_item(32'd6, 32'd4, 32'd6);
    send_item(32'd4, 32'd3, 32'd6);
    send_item(32'd4, 32'd2, 32'd6);
    send_item(32'd3, 32'd1, 32'd7);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFE, 32'd1, 32'hFFFF_FFFF);
    send_item(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFE);
    send_item(32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFB);
    send_item(32'hFFFF_FFFF, 32'd0, 32'h8000_0000);
    send_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFF1);
    send_item(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 77 : 22) : 0;
      recv_stall_pct = (phase == 2) ? 77 : (phase == 3) ? 22 : 0;
      repeat (233) send_random();
    end
    in_valid <= 0;
    recv_stall_pct = 0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #500_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
